// ----- hdl/mgtk_pkg.sv -----
package mgtk_pkg;

	// default grid shape
	localparam int DEF_GRID_ROWS = 8;
	localparam int DEF_GRID_COLS = 16;

	// field widths
	localparam int COUNT_W = 16;
	localparam int TOPK_W  = 7;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 4;

	// stored word: mark, hole, count
	localparam int WORD_W = COUNT_W + 2;

	// most selections per load
	localparam logic [TOPK_W-1:0] MAX_SELECT = 7'd64;

	// input item
	typedef struct packed {
		logic [COUNT_W-1:0] cell_count;
		logic               is_hole;
	} cell_t;

	// result item
	typedef struct packed {
		logic [ROW_W-1:0]   sel_row;
		logic [COL_W-1:0]   sel_col;
		logic [COUNT_W-1:0] sel_count;
		logic               last_of_run;
	} sel_t;

	// controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_REF,
		ST_SEL,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic scan_start;
		logic scan_ref;
		logic emit;
		logic last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic load_last;
		logic scan_done;
		logic scan_busy;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/mgtk_ram.sv -----
module mgtk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/mgtk_ctrl.sv -----
module mgtk_ctrl
	import mgtk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	output logic              cell_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TOPK_W-1:0] cfg_data,
	input  sts_t              sts,
	output cmd_t              cmd
);

	state_t            state_q, state_nxt;
	logic [TOPK_W-1:0] top_k_q;
	logic [TOPK_W-1:0] round_q;
	logic [TOPK_W-1:0] rounds;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= '0;
		end else if (cfg_valid) begin
			top_k_q <= cfg_data;
		end
	end

	// saturated round count
	assign rounds = (top_k_q > MAX_SELECT) ? MAX_SELECT : top_k_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.load_wr && sts.load_last) begin
			round_q <= '0;
		end else if (cmd.emit) begin
			round_q <= round_q + TOPK_W'(1);
		end
	end

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.last       = ((round_q + TOPK_W'(1)) == rounds);
		cell_stall     = 1'b1;
		case (state_q)
			ST_LOAD: begin
				cell_stall = 1'b0;
				if (cell_valid) begin
					cmd.load_wr = 1'b1;
					if (sts.load_last && (rounds != '0)) begin
						cmd.scan_start = 1'b1;
						cmd.scan_ref   = 1'b1;
						state_nxt      = ST_REF;
					end
				end
			end
			ST_REF: begin
				if (sts.scan_done) begin
					cmd.scan_start = 1'b1;
					state_nxt      = ST_SEL;
				end
			end
			ST_SEL: begin
				if (sts.scan_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (cmd.last) begin
						state_nxt = ST_LOAD;
					end else begin
						cmd.scan_start = 1'b1;
						state_nxt      = ST_SEL;
					end
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

endmodule

// ----- hdl/mgtk_dp.sv -----
module mgtk_dp
	import mgtk_pkg::*;
#(
	parameter int GRID_ROWS = DEF_GRID_ROWS,
	parameter int GRID_COLS = DEF_GRID_COLS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t cell_item,
	output sel_t  sel_item,
	output logic  sel_valid,
	input  logic  sel_stall,
	input  cmd_t  cmd,
	output sts_t  sts
);

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
	localparam logic [CW-1:0]    LAST_COL = CW'(GRID_COLS - 1);

	logic [IDX_W-1:0] load_pos_q;

	// scan address side
	logic             scan_act_q;
	logic             scan_ref_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [RW-1:0]    scan_row_q;
	logic [CW-1:0]    scan_col_q;

	// read data side
	logic             rd_vld_s1;
	logic             first_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [RW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;

	// reference and candidate
	logic               ref_hole_q, cand_hole_q;
	logic [COUNT_W-1:0] ref_cnt_q, cand_cnt_q;
	logic [IDX_W-1:0]   ref_idx_q, cand_idx_q;
	logic [RW-1:0]      ref_row_q, cand_row_q;
	logic [CW-1:0]      ref_col_q, cand_col_q;

	// memory ports
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic [WORD_W-1:0]  rd_data;
	logic               rd_mark, rd_hole;
	logic [COUNT_W-1:0] rd_cnt;
	logic [COUNT_W-1:0] base_cnt;
	logic               ref_take, cand_take;

	logic               out_valid_q;
	sel_t               out_q;
	logic [RW+ROW_W-1:0] row_ext;
	logic [CW+COL_W-1:0] col_ext;

	// load position, wraps after the final cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (cmd.load_wr) begin
			load_pos_q <= (load_pos_q == LAST_IDX) ? '0 : load_pos_q + IDX_W'(1);
		end
	end

	// write port: cell load clears the mark, emit sets it
	always_comb begin
		wr_en   = cmd.load_wr || cmd.emit;
		wr_addr = cmd.load_wr ? load_pos_q : cand_idx_q;
		wr_data = cmd.load_wr ? {1'b0, cell_item.is_hole, cell_item.cell_count}
		                      : {1'b1, cand_hole_q, cand_cnt_q};
	end

	mgtk_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELLS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (scan_act_q),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	// scan address counter with row and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			scan_ref_q <= 1'b0;
			scan_idx_q <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
		end else if (cmd.scan_start) begin
			scan_act_q <= 1'b1;
			scan_ref_q <= cmd.scan_ref;
			scan_idx_q <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
		end else if (scan_act_q) begin
			if (scan_idx_q == LAST_IDX) begin
				scan_act_q <= 1'b0;
			end
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (scan_col_q == LAST_COL) begin
				scan_col_q <= '0;
				scan_row_q <= scan_row_q + RW'(1);
			end else begin
				scan_col_q <= scan_col_q + CW'(1);
			end
		end
	end

	// position of the word coming out of memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_act_q;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (scan_idx_q == '0);
		last_s1  <= (scan_idx_q == LAST_IDX);
		idx_s1   <= scan_idx_q;
		row_s1   <= scan_row_q;
		col_s1   <= scan_col_q;
	end

	// compare against the running reference or candidate
	always_comb begin
		{rd_mark, rd_hole, rd_cnt} = rd_data;
		base_cnt  = first_s1 ? ref_cnt_q : cand_cnt_q;
		ref_take  = first_s1 || (!rd_hole && (rd_cnt <= ref_cnt_q));
		cand_take = !rd_hole && !rd_mark && (rd_cnt >= base_cnt);
	end

	// reference update during the reference scan
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && scan_ref_q && ref_take) begin
			ref_hole_q <= rd_hole;
			ref_cnt_q  <= rd_cnt;
			ref_idx_q  <= idx_s1;
			ref_row_q  <= row_s1;
			ref_col_q  <= col_s1;
		end
	end

	// candidate update, seeded from the reference on the first word
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !scan_ref_q) begin
			if (cand_take) begin
				cand_hole_q <= rd_hole;
				cand_cnt_q  <= rd_cnt;
				cand_idx_q  <= idx_s1;
				cand_row_q  <= row_s1;
				cand_col_q  <= col_s1;
			end else if (first_s1) begin
				cand_hole_q <= ref_hole_q;
				cand_cnt_q  <= ref_cnt_q;
				cand_idx_q  <= ref_idx_q;
				cand_row_q  <= ref_row_q;
				cand_col_q  <= ref_col_q;
			end
		end
	end

	// row and column masked to the output widths
	assign row_ext = {{ROW_W{1'b0}}, cand_row_q};
	assign col_ext = {{COL_W{1'b0}}, cand_col_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!sel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.sel_row     <= row_ext[ROW_W-1:0];
			out_q.sel_col     <= col_ext[COL_W-1:0];
			out_q.sel_count   <= cand_cnt_q;
			out_q.last_of_run <= cmd.last;
		end
	end

	assign sel_valid = out_valid_q;
	assign sel_item  = out_q;

	// status
	assign sts.load_last = (load_pos_q == LAST_IDX);
	assign sts.scan_done = rd_vld_s1 && last_s1;
	assign sts.scan_busy = scan_act_q || rd_vld_s1;
	assign sts.out_free  = !out_valid_q || !sel_stall;

endmodule

// ----- hdl/masked_grid_top_k_select.sv -----
// masked_grid_top_k_select: picks the top_k highest-count non-hole cells of a grid
//
// cell channel (cell_valid / cell_stall / cell_item): one cell per transfer,
// row-major, GRID_ROWS*GRID_COLS transfers make one load. Cells are taken one
// per cycle while the block is loading.
// sel channel (sel_valid / sel_stall / sel_item): min(top_k, 64) results per
// load, the final one flagged by last_of_run.
// cfg channel (cfg_valid / cfg_ready / cfg_data): writes top_k; always ready,
// to be written only while the block is idle.
// After the final cell the block runs a reference scan over the cell memory
// (one memory read per cycle), then per selection one scan of the cell memory
// and one load of the output register; cell_stall stays high until the last
// result sits in the output register.
// A stalled receiver holds the output register and pauses selection; the next
// load can start while the last result still waits to be taken.
// Reset (arst_n low) clears the load position, top_k and the output valid.
module masked_grid_top_k_select
	import mgtk_pkg::*;
#(
	parameter int GRID_ROWS = DEF_GRID_ROWS,
	parameter int GRID_COLS = DEF_GRID_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	output logic              cell_stall,
	input  cell_t             cell_item,
	output logic              sel_valid,
	input  logic              sel_stall,
	output sel_t              sel_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TOPK_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencing of load, scans and emits
	mgtk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.sts        (sts),
		.cmd        (cmd)
	);

	// cell memory, compare and output register
	mgtk_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_item (cell_item),
		.sel_item  (sel_item),
		.sel_valid (sel_valid),
		.sel_stall (sel_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// an emit only goes into a free output register
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> sts.out_free)
		else $error("emit while output register busy");

	// a scan only starts when idle or as the previous one hands over its last word
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> (!sts.scan_busy || sts.scan_done))
		else $error("scan started while busy");

	// cell load and mark write never share the write port
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.load_wr && cmd.emit))
		else $error("write port conflict");

	// no cell transfer while a scan is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.scan_busy |-> cell_stall)
		else $error("cell taken during scan");

endmodule
